// File: sv/ltci_pkg.sv
// Shared types and constants for the load transfer contactor interlock.
package ltci_pkg;

  localparam int unsigned DelayW     = 10;
  localparam int unsigned DelayReset = 5;
  localparam int unsigned ApbAddrW   = 3;
  localparam int unsigned ApbDataW   = 32;

  // Register index of the transfer delay (byte address 4*index)
  localparam logic [ApbAddrW-3:0] RegTransferDelay = '0;

  // Saturation point of the seconds counter
  localparam logic [DelayW-1:0] CountMax = '1;

  // Interlock state carried from one transfer to the next
  typedef struct packed {
    logic              pending_mains_request;
    logic              pending_gen_request;
    logic              busy_flag;
    logic              heading_to_mains;
    logic              heading_to_gen;
    logic              gen_closed;
    logic              mains_closed;
    logic [DelayW-1:0] delay_seconds;
  } state_t;

  // Fields of one input transfer
  typedef struct packed {
    logic switch_to_mains_req;
    logic switch_to_gen_req;
    logic open_gen_req;
    logic open_mains_req;
    logic mains_switch_in;
    logic gen_switch_in;
    logic mains_healthy;
    logic manual_ctrl;
    logic warmup_done;
    logic second_tick;
  } item_t;

endpackage

// File: sv/load_transfer_contactor_interlock.sv
// An accepted input transfer's result is registered into the output register.
// Throughput: one transfer per cycle; the state update is a single pass of flag logic
// and 10-bit counter compares; input stalls only while a full result waits on out_ready.
// Reset (rst, synchronous, active high): contactors open, no requests, not busy,
// counter zero, transfer delay 5 s, output register empty.
module load_transfer_contactor_interlock (
  input  logic                           clk,
  input  logic                           rst,
  // APB configuration
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [ltci_pkg::ApbAddrW-1:0]  paddr,
  input  logic [ltci_pkg::ApbDataW-1:0]  pwdata,
  output logic [ltci_pkg::ApbDataW-1:0]  prdata,
  output logic                           pready,
  // Input channel
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           switch_to_mains_req,
  input  logic                           switch_to_gen_req,
  input  logic                           open_gen_req,
  input  logic                           open_mains_req,
  input  logic                           mains_switch_in,
  input  logic                           gen_switch_in,
  input  logic                           mains_healthy,
  input  logic                           manual_ctrl,
  input  logic                           warmup_done,
  input  logic                           second_tick,
  // Output channel
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           close_gen_out,
  output logic                           open_gen_out,
  output logic                           close_mains_out,
  output logic                           open_mains_out,
  output logic                           transfer_busy
);

  logic [ltci_pkg::DelayW-1:0] transfer_delay_s;
  ltci_pkg::state_t            state;
  ltci_pkg::state_t            state_next;
  ltci_pkg::item_t             item;
  logic                        in_xfer;

  ltci_cfg u_cfg (
    .clk              (clk),
    .rst              (rst),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready),
    .transfer_delay_s (transfer_delay_s)
  );

  assign item = '{
    switch_to_mains_req: switch_to_mains_req,
    switch_to_gen_req:   switch_to_gen_req,
    open_gen_req:        open_gen_req,
    open_mains_req:      open_mains_req,
    mains_switch_in:     mains_switch_in,
    gen_switch_in:       gen_switch_in,
    mains_healthy:       mains_healthy,
    manual_ctrl:         manual_ctrl,
    warmup_done:         warmup_done,
    second_tick:         second_tick
  };

  ltci_step u_step (
    .cur              (state),
    .item             (item),
    .transfer_delay_s (transfer_delay_s),
    .nxt              (state_next)
  );

  // Accept whenever the result register is empty or being drained
  assign in_ready = !out_valid || out_ready;
  assign in_xfer  = in_valid && in_ready;

  // Interlock state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (in_xfer) begin
      state <= state_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_xfer) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      close_gen_out   <= state_next.gen_closed;
      open_gen_out    <= !state_next.gen_closed;
      close_mains_out <= state_next.mains_closed;
      open_mains_out  <= !state_next.mains_closed;
      transfer_busy   <= state_next.busy_flag;
    end
  end

`ifndef SYNTHESIS
  // Busy exactly when one heading flag is set
  a_busy_heading: assert property (@(posedge clk) disable iff (rst)
    (state.busy_flag == (state.heading_to_mains || state.heading_to_gen)) &&
    $onehot0({state.heading_to_mains, state.heading_to_gen}))
    else $error("busy flag and heading flags disagree");

  // Break before make: never both contactors closed
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(state.gen_closed && state.mains_closed))
    else $error("both contactors closed");

  // Every accepted transfer leaves a result waiting
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    in_xfer |=> out_valid)
    else $error("accepted transfer produced no result");

  // Result drives reflect the state they were taken from
  a_result_matches: assert property (@(posedge clk) disable iff (rst)
    in_xfer |=> (close_gen_out == state.gen_closed) &&
                (close_mains_out == state.mains_closed) &&
                (transfer_busy == state.busy_flag))
    else $error("result register does not match interlock state");
`endif

endmodule

// File: sv/ltci_cfg.sv
// APB register file holding the transfer delay.
module ltci_cfg (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [ltci_pkg::ApbAddrW-1:0]  paddr,
  input  logic [ltci_pkg::ApbDataW-1:0]  pwdata,
  output logic [ltci_pkg::ApbDataW-1:0]  prdata,
  output logic                           pready,
  output logic [ltci_pkg::DelayW-1:0]    transfer_delay_s
);

  logic wr_en;
  logic hit;

  // Word index decode; byte offset bits are ignored
  assign hit    = (paddr[ltci_pkg::ApbAddrW-1:2] == ltci_pkg::RegTransferDelay);
  assign wr_en  = psel && penable && pwrite && pready && hit;
  assign pready = 1'b1;

  // Delay register
  always_ff @(posedge clk) begin
    if (rst) begin
      transfer_delay_s <= ltci_pkg::DelayW'(ltci_pkg::DelayReset);
    end else if (wr_en) begin
      transfer_delay_s <= pwdata[ltci_pkg::DelayW-1:0];
    end
  end

  // Read mux
  always_comb begin
    prdata = '0;
    if (hit) begin
      prdata = {{(ltci_pkg::ApbDataW-ltci_pkg::DelayW){1'b0}}, transfer_delay_s};
    end
  end

endmodule

// File: sv/ltci_step.sv
// Next-state logic of the interlock for one input transfer.
module ltci_step (
  input  ltci_pkg::state_t              cur,
  input  ltci_pkg::item_t               item,
  input  logic [ltci_pkg::DelayW-1:0]   transfer_delay_s,
  output ltci_pkg::state_t              nxt
);

  always_comb begin
    nxt = cur;

    // Latch request pulses
    if (item.switch_to_mains_req) nxt.pending_mains_request = 1'b1;
    if (item.switch_to_gen_req)   nxt.pending_gen_request   = 1'b1;

    // Seconds counter, saturating
    if (nxt.busy_flag && item.second_tick && (nxt.delay_seconds != ltci_pkg::CountMax)) begin
      nxt.delay_seconds = nxt.delay_seconds + ltci_pkg::DelayW'(1);
    end

    // Serve mains first
    if (!nxt.busy_flag && (nxt.pending_mains_request ||
        (item.mains_switch_in && item.mains_healthy && item.manual_ctrl))) begin
      nxt.busy_flag             = 1'b1;
      nxt.delay_seconds         = '0;
      nxt.pending_mains_request = 1'b0;
      nxt.heading_to_mains      = 1'b1;
      nxt.gen_closed            = 1'b0;
    end

    // Then generator, only if still idle
    if (!nxt.busy_flag && (nxt.pending_gen_request ||
        (item.gen_switch_in && item.warmup_done && item.manual_ctrl))) begin
      nxt.busy_flag           = 1'b1;
      nxt.delay_seconds       = '0;
      nxt.pending_gen_request = 1'b0;
      nxt.heading_to_gen      = 1'b1;
      nxt.mains_closed        = 1'b0;
    end

    // Delay expired: close the target contactor
    if (nxt.busy_flag && (nxt.delay_seconds >= transfer_delay_s)) begin
      nxt.busy_flag = 1'b0;
      if (nxt.heading_to_mains) begin
        nxt.heading_to_mains = 1'b0;
        nxt.mains_closed     = 1'b1;
      end else if (nxt.heading_to_gen) begin
        nxt.heading_to_gen = 1'b0;
        nxt.gen_closed     = 1'b1;
      end
    end

    // Open requests cancel a transfer toward that contactor and open it
    if (item.open_gen_req) begin
      if (nxt.heading_to_gen) begin
        nxt.busy_flag      = 1'b0;
        nxt.heading_to_gen = 1'b0;
      end
      nxt.gen_closed = 1'b0;
    end
    if (item.open_mains_req) begin
      if (nxt.heading_to_mains) begin
        nxt.busy_flag        = 1'b0;
        nxt.heading_to_mains = 1'b0;
      end
      nxt.mains_closed = 1'b0;
    end
  end

endmodule
